/* src/pea_pkg.sv */
`default_nettype none
package pea_pkg;

  localparam int PAGE_BITS   = 20;
  localparam int COUNT_BITS  = PAGE_BITS + 1;
  localparam int MAX_RECORDS_DEF = 64;

  localparam logic [1:0] REC_EMPTY = 2'd0;
  localparam logic [1:0] REC_FREE  = 2'd1;
  localparam logic [1:0] REC_USED  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_POOLFULL = 2'd3;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_START  = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COUNT_BITS-1:0] page_count;
    logic [PAGE_BITS-1:0]  block_start;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PAGE_BITS-1:0]  start_page;
    logic [COUNT_BITS-1:0] free_pages_left;
  } res_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PAGE_BITS-1:0]  start;
    logic [COUNT_BITS-1:0] len;
  } rec_t;

endpackage
`default_nettype wire

/* src/page_extent_allocator_unit.sv */
`default_nettype none
// Allocate scans the ring for a fit, then rewrites it; free scans for the block and its lower
// neighbour, then its upper one, then rewrites; restart only rewrites. No fit, a full pool or
// an unknown start ends after the first scan; a zero or oversized allocate or an unknown kind
// skips the ring. One item is in work at a time; the next is taken the cycle after its result
// is loaded, and a stalled result holds the unit. The record ring rotates once per pass. Reset
// (synchronous, rst_n low) empties every record and zeroes the free total and config registers.
module page_extent_allocator_unit
  import pea_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire req_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output res_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_idx,
  input  wire logic [COUNT_BITS-1:0] cfg_wdata
);

  localparam int IDXW = $clog2(MAX_RECORDS);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_RECORDS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIT, S_FITCHK, S_FIND, S_FINDCHK, S_HI, S_APPLY, S_DONE
  } state_t;

  state_t state_r;

  logic [1:0]            policy_r;
  logic [PAGE_BITS-1:0]  mem_start_r;
  logic [COUNT_BITS-1:0] mem_count_r;
  logic [COUNT_BITS-1:0] total_r;

  logic [1:0]            kind_r;
  logic [COUNT_BITS-1:0] n_r;
  logic [PAGE_BITS-1:0]  a_r;
  logic [IDXW-1:0]       t_r;

  logic                  best_vld_r, emp_vld_r, k_vld_r, lo_vld_r, hi_vld_r;
  logic [IDXW-1:0]       best_idx_r, emp_idx_r, k_idx_r, lo_idx_r, hi_idx_r;
  logic [COUNT_BITS-1:0] best_len_r, k_len_r, lo_len_r, hi_len_r;
  logic [PAGE_BITS-1:0]  best_start_r;

  res_t res_r;
  logic out_valid_r;
  res_t out_data_r;

  rec_t ring_q [MAX_RECORDS];
  rec_t head, wb;
  logic shift_en;

  assign shift_en = (state_r == S_FIT) || (state_r == S_FIND) || (state_r == S_HI) ||
                    (state_r == S_APPLY);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
      rec_t d;
      if (gi == MAX_RECORDS - 1) begin : g_tail
        assign d = wb;
      end else begin : g_mid
        assign d = ring_q[gi+1];
      end
      pea_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (d),
        .q        (ring_q[gi])
      );
    end
  endgenerate

  assign head = ring_q[0];

  logic [PAGE_BITS+1:0]  head_end, k_end;
  logic                  fits, take;
  logic [COUNT_BITS-1:0] room, rs_count;
  logic                  split;
  logic                  bad_alloc;

  assign head_end  = {2'b00, head.start} + {1'b0, head.len};
  assign k_end     = {2'b00, a_r} + {1'b0, k_len_r};
  assign fits      = (head.status == REC_FREE) && (head.len >= n_r);
  assign room      = {1'b1, {PAGE_BITS{1'b0}}} - {1'b0, mem_start_r};
  assign rs_count  = (mem_count_r > room) ? room : mem_count_r;
  assign split     = (best_len_r != n_r);
  assign bad_alloc = (in_data.page_count == '0) || (in_data.page_count > total_r);

  always_comb begin
    unique case (policy_r)
      POL_BEST:  take = (head.len < best_len_r) ||
                        ((head.len == best_len_r) && (head.start < best_start_r));
      POL_WORST: take = (head.len > best_len_r) ||
                        ((head.len == best_len_r) && (head.start < best_start_r));
      default:   take = head.start < best_start_r;
    endcase
  end

  // record written back into the tail of the ring
  always_comb begin
    wb = head;
    if (state_r == S_APPLY) begin
      priority case (kind_r)
        KIND_ALLOC: begin
          if (t_r == best_idx_r) begin
            if (!split) begin
              wb.status = REC_USED;
            end else begin
              wb.start = head.start + n_r[PAGE_BITS-1:0];
              wb.len   = head.len - n_r;
            end
          end else if (split && (t_r == emp_idx_r)) begin
            wb.status = REC_USED;
            wb.start  = best_start_r;
            wb.len    = n_r;
          end
        end
        KIND_FREE: begin
          if (t_r == k_idx_r) begin
            if (lo_vld_r) begin
              wb.status = REC_EMPTY;
            end else begin
              wb.status = REC_FREE;
              wb.len    = k_len_r + (hi_vld_r ? hi_len_r : '0);
            end
          end else if (lo_vld_r && (t_r == lo_idx_r)) begin
            wb.len = lo_len_r + k_len_r + (hi_vld_r ? hi_len_r : '0);
          end else if (hi_vld_r && (t_r == hi_idx_r)) begin
            wb.status = REC_EMPTY;
          end
        end
        default: begin
          if ((t_r == '0) && (rs_count != '0)) begin
            wb.status = REC_FREE;
            wb.start  = mem_start_r;
            wb.len    = rs_count;
          end else begin
            wb.status = REC_EMPTY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= '0;
      mem_start_r <= '0;
      mem_count_r <= '0;
    end else if (cfg_we) begin
      priority case (cfg_idx)
        CFG_POLICY: policy_r    <= cfg_wdata[1:0];
        CFG_START:  mem_start_r <= cfg_wdata[PAGE_BITS-1:0];
        CFG_COUNT:  mem_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      t_r         <= '0;
    end else begin
      // in S_DONE the output register is reloaded below
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (shift_en) begin
        t_r <= (t_r == LAST_IDX) ? '0 : t_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= in_data.kind;
            n_r        <= in_data.page_count;
            a_r        <= in_data.block_start;
            best_vld_r <= 1'b0;
            emp_vld_r  <= 1'b0;
            k_vld_r    <= 1'b0;
            lo_vld_r   <= 1'b0;
            hi_vld_r   <= 1'b0;
            t_r        <= '0;
            res_r      <= '{status: ((in_data.kind == KIND_ALLOC) && bad_alloc) ?
                                    ST_NOSPACE : ST_OK,
                            start_page: '0, free_pages_left: total_r};
            unique case (in_data.kind)
              KIND_ALLOC:   state_r <= bad_alloc ? S_DONE : S_FIT;
              KIND_FREE:    state_r <= S_FIND;
              KIND_RESTART: state_r <= S_APPLY;
              default:      state_r <= S_DONE;
            endcase
          end
        end
        S_FIT: begin
          if (fits && (!best_vld_r || take)) begin
            best_vld_r   <= 1'b1;
            best_idx_r   <= t_r;
            best_len_r   <= head.len;
            best_start_r <= head.start;
          end
          if (!emp_vld_r && (head.status == REC_EMPTY)) begin
            emp_vld_r <= 1'b1;
            emp_idx_r <= t_r;
          end
          if (t_r == LAST_IDX) begin
            state_r <= S_FITCHK;
          end
        end
        S_FITCHK: begin
          if (!best_vld_r) begin
            res_r.status <= ST_NOSPACE;
            state_r      <= S_DONE;
          end else if (split && !emp_vld_r) begin
            res_r.status <= ST_POOLFULL;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_APPLY;
          end
        end
        S_FIND: begin
          if (!k_vld_r && (head.status == REC_USED) && (head.start == a_r)) begin
            k_vld_r <= 1'b1;
            k_idx_r <= t_r;
            k_len_r <= head.len;
          end
          if (!lo_vld_r && (head.status == REC_FREE) && (head_end == {2'b00, a_r})) begin
            lo_vld_r <= 1'b1;
            lo_idx_r <= t_r;
            lo_len_r <= head.len;
          end
          if (t_r == LAST_IDX) begin
            state_r <= S_FINDCHK;
          end
        end
        S_FINDCHK: begin
          if (!k_vld_r) begin
            res_r.status <= ST_NOTFOUND;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_HI;
          end
        end
        S_HI: begin
          if (!hi_vld_r && (head.status == REC_FREE) && ({2'b00, head.start} == k_end)) begin
            hi_vld_r <= 1'b1;
            hi_idx_r <= t_r;
            hi_len_r <= head.len;
          end
          if (t_r == LAST_IDX) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (t_r == LAST_IDX) begin
            state_r <= S_DONE;
            priority case (kind_r)
              KIND_ALLOC: begin
                total_r <= total_r - n_r;
                res_r   <= '{status: ST_OK, start_page: best_start_r,
                             free_pages_left: total_r - n_r};
              end
              KIND_FREE: begin
                total_r <= total_r + k_len_r;
                res_r   <= '{status: ST_OK, start_page: '0,
                             free_pages_left: total_r + k_len_r};
              end
              default: begin
                total_r <= rs_count;
                res_r   <= '{status: ST_OK, start_page: '0, free_pages_left: rs_count};
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* src/pea_cell.sv */
`default_nettype none
module pea_cell
  import pea_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire rec_t d_in,
  output rec_t      q
);

  logic [1:0]            status_r;
  logic [PAGE_BITS-1:0]  start_r;
  logic [COUNT_BITS-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= REC_EMPTY;
    end else if (shift_en) begin
      status_r <= d_in.status;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      start_r <= d_in.start;
      len_r   <= d_in.len;
    end
  end

  assign q = '{status: status_r, start: start_r, len: len_r};

endmodule
`default_nettype wire

/* tb/alloc_checker.sv */
`timescale 1ns / 100ps
module alloc_checker
  import pea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire req_t                  in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire res_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_idx,
  input  wire logic [COUNT_BITS-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  localparam int NREC = MAX_RECORDS_DEF;
  localparam logic [COUNT_BITS-1:0] PAGE_SPACE = {1'b1, {PAGE_BITS{1'b0}}};

  logic [1:0]            ext_state [NREC];
  logic [PAGE_BITS-1:0]  ext_base  [NREC];
  logic [COUNT_BITS-1:0] ext_len   [NREC];
  logic [COUNT_BITS-1:0] pages_free;
  logic [1:0]            policy;
  logic [PAGE_BITS-1:0]  mem_base;
  logic [COUNT_BITS-1:0] mem_pages;
  res_t                  expected_q[$];

  task automatic report_miss(input string field, input longint want, input longint got);
    $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $time);
    fail_count++;
  endtask

  function automatic void clear_pool();
    for (int i = 0; i < NREC; i++) begin
      ext_state[i] = REC_EMPTY;
      ext_base[i] = '0;
      ext_len[i] = '0;
    end
    pages_free = '0;
  endfunction

  function automatic void do_allocate(input logic [COUNT_BITS-1:0] n, ref res_t r);
    int pick;
    int hole;
    logic take;
    pick = -1;
    hole = -1;
    if (n == 0 || n > pages_free) begin
      r.status = ST_NOSPACE;
      return;
    end
    for (int i = 0; i < NREC; i++) begin
      if (ext_state[i] != REC_FREE || ext_len[i] < n) continue;
      if (pick < 0) begin
        pick = i;
        continue;
      end
      if (policy == POL_BEST)
        take = ext_len[i] < ext_len[pick] ||
               (ext_len[i] == ext_len[pick] && ext_base[i] < ext_base[pick]);
      else if (policy == POL_WORST)
        take = ext_len[i] > ext_len[pick] ||
               (ext_len[i] == ext_len[pick] && ext_base[i] < ext_base[pick]);
      else
        take = ext_base[i] < ext_base[pick];
      if (take) pick = i;
    end
    if (pick < 0) begin
      r.status = ST_NOSPACE;
      return;
    end
    if (ext_len[pick] == n) begin
      ext_state[pick] = REC_USED;
    end else begin
      for (int i = NREC - 1; i >= 0; i--)
        if (ext_state[i] == REC_EMPTY) hole = i;
      if (hole < 0) begin
        r.status = ST_POOLFULL;
        return;
      end
      ext_state[hole] = REC_USED;
      ext_base[hole] = ext_base[pick];
      ext_len[hole] = n;
      ext_base[pick] = ext_base[pick] + n[PAGE_BITS-1:0];
      ext_len[pick] = ext_len[pick] - n;
    end
    r.start_page = (ext_state[pick] == REC_USED) ? ext_base[pick]
                                                : ext_base[pick] - n[PAGE_BITS-1:0];
    pages_free = pages_free - n;
  endfunction

  function automatic void do_release(input logic [PAGE_BITS-1:0] a, ref res_t r);
    int k;
    int lo;
    int hi;
    logic [COUNT_BITS:0] tail;
    k = -1;
    lo = -1;
    hi = -1;
    for (int i = 0; i < NREC; i++)
      if (k < 0 && ext_state[i] == REC_USED && ext_base[i] == a) k = i;
    if (k < 0) begin
      r.status = ST_NOTFOUND;
      return;
    end
    ext_state[k] = REC_FREE;
    pages_free = pages_free + ext_len[k];
    tail = {2'b0, ext_base[k]} + {1'b0, ext_len[k]};
    for (int i = 0; i < NREC; i++) begin
      if (i == k || ext_state[i] != REC_FREE) continue;
      if (lo < 0 && ({2'b0, ext_base[i]} + {1'b0, ext_len[i]}) == {2'b0, ext_base[k]}) lo = i;
      if (hi < 0 && {2'b0, ext_base[i]} == tail) hi = i;
    end
    if (lo >= 0) begin
      ext_len[lo] = ext_len[lo] + ext_len[k];
      ext_state[k] = REC_EMPTY;
      k = lo;
    end
    if (hi >= 0) begin
      ext_len[k] = ext_len[k] + ext_len[hi];
      ext_state[hi] = REC_EMPTY;
    end
  endfunction

  function automatic res_t predict_request(input req_t q);
    res_t r;
    logic [COUNT_BITS-1:0] room;
    logic [COUNT_BITS-1:0] cnt;
    r = '0;
    case (q.kind)
      KIND_ALLOC: do_allocate(q.page_count, r);
      KIND_FREE: do_release(q.block_start, r);
      KIND_RESTART: begin
        clear_pool();
        room = PAGE_SPACE - {1'b0, mem_base};
        cnt = (mem_pages > room) ? room : mem_pages;
        if (cnt != 0) begin
          ext_state[0] = REC_FREE;
          ext_base[0] = mem_base;
          ext_len[0] = cnt;
          pages_free = cnt;
        end
      end
      default: ;
    endcase
    r.free_pages_left = pages_free;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      clear_pool();
      fail_count = 0;
      policy <= '0;
      mem_base <= '0;
      mem_pages <= '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_POLICY: policy <= cfg_wdata[1:0];
          CFG_START: mem_base <= cfg_wdata[PAGE_BITS-1:0];
          CFG_COUNT: mem_pages <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_request(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_miss("result count", longint'(0), longint'(1));
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status)
            report_miss("status", longint'(want.status), longint'(out_data.status));
          if (out_data.start_page !== want.start_page)
            report_miss("start_page", longint'(want.start_page),
                        longint'(out_data.start_page));
          if (out_data.free_pages_left !== want.free_pages_left)
            report_miss("free_pages_left", longint'(want.free_pages_left),
                        longint'(out_data.free_pages_left));
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import pea_pkg::*;

  localparam logic [1:0] POL_FIRST     = 2'd0;
  localparam logic [1:0] POL_FIRST_ALT = 2'd3;
  localparam logic [1:0] KIND_NONE     = 2'd3;
  localparam int SETTLE_CYCLES = 3 * MAX_RECORDS_DEF + 16;
  localparam int STALL_LIMIT   = 50000;
  localparam logic [COUNT_BITS-1:0] FULL_SPAN = {1'b1, {PAGE_BITS{1'b0}}};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [COUNT_BITS-1:0] cfg_wdata;
  int fail_count;
  int pending;
  int idle_in;
  int idle_out;
  int quiet_cycles;
  logic [1:0] sent_kinds[$];
  logic [PAGE_BITS-1:0] live_blocks[$];
  logic [COUNT_BITS-1:0] pool_pages;

  page_extent_allocator_unit DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  alloc_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < idle_out);

  // track which blocks are live so frees mostly hit real allocations
  always @(posedge clk) begin
    logic [1:0] k;
    if (in_valid && !in_stall) sent_kinds.push_back(in_data.kind);
    if (out_valid && !out_stall && sent_kinds.size() > 0) begin
      k = sent_kinds.pop_front();
      if (k == KIND_RESTART) live_blocks.delete();
      if (k == KIND_ALLOC && out_data.status == ST_OK) live_blocks.push_back(out_data.start_page);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [COUNT_BITS-1:0] cnt,
                           input logic [PAGE_BITS-1:0] base);
    req_t r;
    r.kind = kind;
    r.page_count = cnt;
    r.block_start = base;
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0 || sent_kinds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [COUNT_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_pool(input logic [1:0] pol, input logic [PAGE_BITS-1:0] base,
                            input logic [COUNT_BITS-1:0] pages);
    drain();
    write_reg(CFG_POLICY, COUNT_BITS'(pol));
    write_reg(CFG_START, {1'b0, base});
    write_reg(CFG_COUNT, pages);
    pool_pages = pages;
    send_item(KIND_RESTART, '0, '0);
  endtask

  task automatic random_item();
    int pick;
    int idx;
    logic [COUNT_BITS-1:0] n;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // mostly small requests so the pool fragments and fills its records
      if ($urandom_range(9) < 7) n = COUNT_BITS'($urandom_range(1, 8));
      else if ($urandom_range(1) == 0) n = COUNT_BITS'($urandom_range(0, pool_pages));
      else n = COUNT_BITS'($urandom);
      send_item(KIND_ALLOC, n, PAGE_BITS'($urandom));
    end else if (pick < 86 && live_blocks.size() > 0) begin
      idx = $urandom_range(live_blocks.size() - 1);
      send_item(KIND_FREE, COUNT_BITS'($urandom), live_blocks[idx]);
      live_blocks.delete(idx);
    end else if (pick < 89) begin
      send_item(KIND_RESTART, COUNT_BITS'($urandom), PAGE_BITS'($urandom));
    end else if (pick < 95) begin
      send_item(KIND_FREE, COUNT_BITS'($urandom), PAGE_BITS'($urandom));
    end else begin
      send_item(($urandom_range(1) == 0) ? KIND_NONE : KIND_ALLOC, '0, PAGE_BITS'($urandom));
    end
  endtask

  task automatic run_phase(input int items);
    for (int i = 0; i < items; i++) begin
      random_item();
      // one hold-off mid phase until everything in flight has come back
      if (i == items / 2) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    idle_in = 22;
    idle_out = 59;
    pool_pages = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // requests against the reset-state empty pool
    send_item(KIND_ALLOC, 1, '0);
    send_item(KIND_FREE, '0, '0);
    send_item(KIND_RESTART, '0, '0);

    setup_pool(POL_FIRST, '0, FULL_SPAN);
    send_item(KIND_ALLOC, '0, '0);
    send_item(KIND_ALLOC, '1, '0);
    send_item(KIND_ALLOC, FULL_SPAN, '0);
    send_item(KIND_ALLOC, 1, '0);
    send_item(KIND_FREE, '0, '0);
    send_item(KIND_FREE, '0, '0);
    send_item(KIND_ALLOC, 10, '0);
    send_item(KIND_ALLOC, 20, '0);
    send_item(KIND_ALLOC, 5, '0);
    send_item(KIND_FREE, '1, 10);
    send_item(KIND_FREE, '0, '0);
    send_item(KIND_FREE, '0, 30);
    send_item(KIND_FREE, '0, '1);
    send_item(KIND_NONE, '1, '1);
    send_item(KIND_ALLOC, FULL_SPAN + 1'b1, '0);
    send_item(KIND_RESTART, '0, '0);
    run_phase(180);

    setup_pool(POL_BEST, 1000, 300);
    run_phase(200);
    setup_pool(POL_WORST, '1, FULL_SPAN);
    run_phase(60);

    idle_in = 59;
    idle_out = 22;
    setup_pool(POL_FIRST_ALT, 20'hFFF00, '0);
    run_phase(25);
    setup_pool(POL_BEST, 20'h80000, 500);
    run_phase(250);

    idle_in = 0;
    idle_out = 0;
    setup_pool(POL_WORST, 12345, 100000);
    run_phase(260);
    setup_pool(POL_FIRST, 7, 120);
    run_phase(260);

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
src/pea_pkg.sv
src/pea_cell.sv
src/page_extent_allocator_unit.sv
tb/alloc_checker.sv
tb/tb_top.sv
